// ----- hdl/dlse_pkg.sv -----
// ----------------------------------------------------------------------------
// dlse_pkg - shared definitions for the dual LIFO stack engine
// Sizes, operation and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package dlse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int DEPTH_W     = 7;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_PUSH   = 2'd0;
	localparam op_t OP_POP    = 2'd1;
	localparam op_t OP_SEARCH = 2'd2;
	localparam op_t OP_CMP    = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request
		logic exec;     // push/pop, set up scan
		logic scan_rd;  // read one entry, advance index
		logic out_load; // fill the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic scan_end;
	} sts_t;

endpackage

// ----- hdl/dlse_req_if.sv -----
// ----------------------------------------------------------------------------
// dlse_req_if - request channel of the stack engine
// Valid/ready handshake with operation, stack select and data word.
// ----------------------------------------------------------------------------
interface dlse_req_if;
	logic                             valid;
	logic                             ready;
	dlse_pkg::op_t                    op;
	logic                             stack_sel;
	logic signed [dlse_pkg::WORD_W-1:0] value;

	modport source (output valid, output op, output stack_sel, output value, input ready);
	modport sink   (input valid, input op, input stack_sel, input value, output ready);
endinterface

// ----- hdl/dlse_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dlse_rsp_if - result channel of the stack engine
// Valid/ready handshake with status, search/compare flags and depth.
// ----------------------------------------------------------------------------
interface dlse_rsp_if;
	logic                          valid;
	logic                          ready;
	dlse_pkg::status_t             status;
	logic                          found;
	logic                          equal;
	logic [dlse_pkg::DEPTH_W-1:0]  depth;

	modport source (output valid, output status, output found, output equal, output depth,
		input ready);
	modport sink   (input valid, input status, input found, input equal, input depth,
		output ready);
endinterface

// ----- hdl/dual_lifo_stack_engine_top.sv -----
// ----------------------------------------------------------------------------
// dual_lifo_stack_engine_top - two bounded LIFO stacks of 32-bit words
// Push, pop, search and stack compare behind valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: op (push, pop, search, compare), stack_sel and
//   value. rsp returns exactly one result per request: status, found, equal
//   and the depth of the selected stack after the operation.
//   Requests are handled one at a time. Push and pop pass through accept,
//   execute and hand-off; the result register loads at hand-off.
//   Search and compare add a scan of N entries between execute and
//   hand-off, reading one entry of each stack memory per cycle over one
//   read port per memory, N being the depth of the stack searched
//   (compare: 0 when depths differ).
//   The result sits in an output register: a new request is accepted and
//   processed while an earlier result waits; only the hand-off stalls until
//   the receiver takes it, and the next request is then taken right after.
//   Reset (arst_n low) empties both stacks and drops any pending result;
//   the stack memories themselves are not cleared, nor need they be.
// ----------------------------------------------------------------------------
module dual_lifo_stack_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	dlse_req_if.sink    req,
	dlse_rsp_if.source  rsp
);

	dlse_pkg::cmd_t cmd;
	dlse_pkg::sts_t sts;

	// sequencer: owns handshake and result-valid flag
	dlse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: stack memories, counts, scan and result payload
	dlse_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_op        (req.op),
		.req_stack_sel (req.stack_sel),
		.req_value     (req.value),
		.rsp_status    (rsp.status),
		.rsp_found     (rsp.found),
		.rsp_equal     (rsp.equal),
		.rsp_depth     (rsp.depth)
	);

	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.scan_rd, cmd.out_load}))
		else $error("more than one datapath command");

	// one request in flight: busy in the cycle after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// never overwrite an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten");

	// no reads past the scan limit
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> !sts.scan_end)
		else $error("scan read beyond limit");

endmodule

// ----- hdl/dlse_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlse_ctrl - sequencer of the stack engine
// Steps each request through execute, entry scan (search and compare only) and result hand-off.
// ----------------------------------------------------------------------------
module dlse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  dlse_pkg::sts_t  sts,
	output dlse_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				unique case (sts.op) inside
					dlse_pkg::OP_SEARCH, dlse_pkg::OP_CMP: state_nxt = S_SCAN;
					default: state_nxt = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (!sts.scan_end) begin
					cmd.scan_rd = 1'b1;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				// result register free, or being emptied this cycle
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- hdl/dlse_dp.sv -----
// ----------------------------------------------------------------------------
// dlse_dp - datapath of the stack engine
// Two stack memories, entry counts, scan index, match flags, result register.
// ----------------------------------------------------------------------------
module dlse_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dlse_pkg::cmd_t                    cmd,
	output dlse_pkg::sts_t                    sts,
	input  dlse_pkg::op_t                     req_op,
	input  logic                              req_stack_sel,
	input  logic signed [dlse_pkg::WORD_W-1:0] req_value,
	output dlse_pkg::status_t                 rsp_status,
	output logic                              rsp_found,
	output logic                              rsp_equal,
	output logic [dlse_pkg::DEPTH_W-1:0]      rsp_depth
);

	localparam int CW = dlse_pkg::CNT_W;
	localparam int AW = dlse_pkg::ADDR_W;
	localparam int WW = dlse_pkg::WORD_W;

	// stack memories, no reset
	logic [WW-1:0] mem0 [dlse_pkg::STACK_DEPTH];
	logic [WW-1:0] mem1 [dlse_pkg::STACK_DEPTH];

	dlse_pkg::op_t     op_q;
	logic              sel_q;
	logic [WW-1:0]     val_q;
	logic [CW-1:0]     cnt0_q, cnt1_q;
	logic [CW-1:0]     idx_q, limit_q;
	dlse_pkg::status_t status_q;
	logic              found_q, match_q;
	logic [WW-1:0]     rd0_s1, rd1_s1;
	logic              rd_vld_s1;

	dlse_pkg::status_t res_status_q;
	logic              res_found_q, res_equal_q;
	logic [dlse_pkg::DEPTH_W-1:0] res_depth_q;

	logic [CW-1:0] cnt_sel;
	logic          is_full, is_empty;
	logic          wr0, wr1;
	logic [WW-1:0] rd_sel;

	assign cnt_sel  = sel_q ? cnt1_q : cnt0_q;
	assign is_full  = (cnt_sel == CW'(dlse_pkg::STACK_DEPTH));
	assign is_empty = (cnt_sel == '0);
	assign wr0      = cmd.exec && (op_q == dlse_pkg::OP_PUSH) && !is_full && !sel_q;
	assign wr1      = cmd.exec && (op_q == dlse_pkg::OP_PUSH) && !is_full && sel_q;
	assign rd_sel   = sel_q ? rd1_s1 : rd0_s1;

	assign sts.op       = op_q;
	assign sts.scan_end = (idx_q == limit_q);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_op;
			sel_q <= req_stack_sel;
			val_q <= req_value;
		end
	end

	// memory write ports
	always_ff @(posedge clk) begin
		if (wr0) begin
			mem0[cnt0_q[AW-1:0]] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr1) begin
			mem1[cnt1_q[AW-1:0]] <= val_q;
		end
	end

	// memory read ports, registered
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd0_s1 <= mem0[idx_q[AW-1:0]];
			rd1_s1 <= mem1[idx_q[AW-1:0]];
		end
	end

	// counts and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt0_q    <= '0;
			cnt1_q    <= '0;
			idx_q     <= '0;
			limit_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_rd) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.exec) begin
				idx_q <= '0;
				unique case (op_q)
					dlse_pkg::OP_PUSH: begin
						limit_q <= '0;
						if (!is_full) begin
							if (sel_q) cnt1_q <= cnt1_q + CW'(1);
							else       cnt0_q <= cnt0_q + CW'(1);
						end
					end
					dlse_pkg::OP_POP: begin
						limit_q <= '0;
						if (!is_empty) begin
							if (sel_q) cnt1_q <= cnt1_q - CW'(1);
							else       cnt0_q <= cnt0_q - CW'(1);
						end
					end
					dlse_pkg::OP_SEARCH: limit_q <= cnt_sel;
					dlse_pkg::OP_CMP:    limit_q <= (cnt0_q == cnt1_q) ? cnt0_q : '0;
					default:             limit_q <= '0;
				endcase
			end
		end
	end

	// status and match flags
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			found_q  <= 1'b0;
			match_q  <= (op_q == dlse_pkg::OP_CMP) && (cnt0_q == cnt1_q);
			if ((op_q == dlse_pkg::OP_PUSH) && is_full)      status_q <= dlse_pkg::ST_FULL;
			else if ((op_q == dlse_pkg::OP_POP) && is_empty) status_q <= dlse_pkg::ST_EMPTY;
			else                                             status_q <= dlse_pkg::ST_OK;
		end else if (rd_vld_s1) begin
			if ((op_q == dlse_pkg::OP_SEARCH) && (rd_sel == val_q)) found_q <= 1'b1;
			if ((op_q == dlse_pkg::OP_CMP) && (rd0_s1 != rd1_s1))   match_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_status_q <= status_q;
			res_found_q  <= found_q;
			res_equal_q  <= match_q;
			res_depth_q  <= dlse_pkg::DEPTH_W'(cnt_sel);
		end
	end

	assign rsp_status = res_status_q;
	assign rsp_found  = res_found_q;
	assign rsp_equal  = res_equal_q;
	assign rsp_depth  = res_depth_q;

endmodule
